// File: rtl/utf8_stream_decoder_assert.svh
// Assertion macros used by the decoder top module.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define UTF8SD_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("utf8 decoder check failed");

// Consequence that must hold in the same cycle as the antecedent.
`define UTF8SD_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 decoder check failed");

// Consequence that must hold in the cycle after the antecedent.
`define UTF8SD_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 decoder check failed");

`endif

// File: rtl/utf8_sd_pkg.sv
package utf8_sd_pkg;

   localparam int CP_W        = 21;
   localparam int LEN_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;
   localparam logic [7:0] CONT_BITS  = 8'h3F;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final_byte;
   } in_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] bytes_used;
      logic             malformed;
      logic             run_last;
      logic             text_done;
   } out_type;

   typedef struct packed {
      logic [CP_W-1:0]  partial_value;
      logic [LEN_W-1:0] expected_length;
      logic [LEN_W-1:0] bytes_seen;
   } state_type;

   typedef struct packed {
      logic [1:0]        count;
      out_type [1:0]     results;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   function automatic out_type make_result(input logic [CP_W-1:0] cp,
                                           input logic [LEN_W-1:0] used,
                                           input logic bad);
      out_type r;
      r.code_point = cp;
      r.bytes_used = used;
      r.malformed  = bad;
      r.run_last   = 1'b0;
      r.text_done  = 1'b0;
      return r;
   endfunction

endpackage

// File: rtl/utf8_sd_core.sv
module utf8_sd_core
   import utf8_sd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  in_type    item,
   output push_type  push,
   output state_type state
);

   state_type  state_ff;
   state_type  state_in;
   logic [7:0] b;
   logic       fin;
   logic       do_lead;
   logic [1:0] n;
   out_type [1:0] res;
   logic [CP_W-1:0]  pv;
   logic [LEN_W-1:0] el;
   logic [LEN_W-1:0] sn;

   assign b   = item.text_byte;
   assign fin = item.is_final_byte;

   always_comb begin
      pv      = state_ff.partial_value;
      el      = state_ff.expected_length;
      sn      = state_ff.bytes_seen;
      n       = 2'd0;
      res     = '0;
      do_lead = 1'b0;

      if (el != '0) begin
         if ((b & CONT_MASK) == CONT_CODE) begin
            pv = {pv[CP_W-7:0], b[5:0] & CONT_BITS[5:0]};
            sn = sn + LEN_ONE;
            if (sn >= el) begin
               res[n[0]] = make_result(pv, sn, 1'b0);
               n  = n + 2'd1;
               pv = '0;
               el = '0;
               sn = '0;
            end
         end else begin
            res[n[0]] = make_result(REPLACEMENT_CP, sn, 1'b1);
            n       = n + 2'd1;
            pv      = '0;
            el      = '0;
            sn      = '0;
            do_lead = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         if (!b[7]) begin
            res[n[0]] = make_result(CP_W'(b), LEN_ONE, 1'b0);
            n = n + 2'd1;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            pv = CP_W'(b & LEAD2_BITS);
            el = LEN_TWO;
            sn = LEN_ONE;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            pv = CP_W'(b & LEAD3_BITS);
            el = LEN_THREE;
            sn = LEN_ONE;
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            pv = CP_W'(b & LEAD4_BITS);
            el = LEN_FOUR;
            sn = LEN_ONE;
         end else begin
            res[n[0]] = make_result(REPLACEMENT_CP, LEN_ONE, 1'b1);
            n = n + 2'd1;
         end
      end

      if (fin && (el != '0)) begin
         res[n[0]] = make_result(REPLACEMENT_CP, sn, 1'b1);
         n  = n + 2'd1;
         pv = '0;
         el = '0;
         sn = '0;
      end

      if (n != 2'd0) begin
         res[~n[0]].run_last  = 1'b1;
         res[~n[0]].text_done = fin;
      end

      state_in.partial_value   = pv;
      state_in.expected_length = el;
      state_in.bytes_seen      = sn;
      push.count   = accept ? n : 2'd0;
      push.results = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// File: rtl/utf8_sd_queue.sv
module utf8_sd_queue
   import utf8_sd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output out_type          head,
   output queue_status_type status
);

   out_type           qmem_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff;
   logic [QIDX_W-1:0] wr_ptr_in;
   logic [QIDX_W-1:0] wr_next;
   logic [QIDX_W-1:0] rd_ptr_ff;
   logic [QIDX_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign wr_next   = wr_ptr_ff + QIDX_W'(1);
   assign wr_ptr_in = wr_ptr_ff + QIDX_W'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + QIDX_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         qmem_ff[wr_ptr_ff] <= push.results[0];
      end
      if (push.count == 2'd2) begin
         qmem_ff[wr_next] <= push.results[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head         = qmem_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

// File: rtl/utf8_stream_decoder.sv
// Channel   Direction  Payload   Handshake
// req_      in         in_type   req_valid / req_stall
// rsp_      out        out_type  rsp_valid / rsp_stall
//
// One byte is taken per cycle while req_stall is low; its results are written to a
// four-entry result queue in the same cycle and can leave from the next cycle on.
// The result side moves one code point per cycle while rsp_stall is low; a byte with
// two results fills two slots, and req_stall rises when fewer than two are free.
// Reset is synchronous and closes any open sequence and empties the queue.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
   import utf8_sd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  in_type  req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output out_type rsp_data
);

   logic             accept;
   logic             pop;
   push_type         push;
   state_type        state;
   queue_status_type qstat;

   assign req_stall = qstat.count > QCNT_W'(QUEUE_DEPTH - 2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = qstat.count != '0;
   assign pop       = rsp_valid && !rsp_stall;

   utf8_sd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .push   (push),
      .state  (state)
   );

   utf8_sd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (rsp_data),
      .status (qstat)
   );

   `UTF8SD_ALWAYS(a_queue_bound, qstat.count <= QCNT_W'(QUEUE_DEPTH))
   `UTF8SD_SAME(a_seen_nonzero, state.expected_length != '0, state.bytes_seen != '0)
   `UTF8SD_SAME(a_seen_low, state.expected_length != '0, state.bytes_seen < state.expected_length)
   `UTF8SD_NEXT(a_final_closes, accept && req_data.is_final_byte, state.expected_length == '0)
   `UTF8SD_SAME(a_bad_is_fffd, rsp_valid && rsp_data.malformed, rsp_data.code_point == REPLACEMENT_CP)

endmodule

// File: sim/tb_top.sv
module tb_top;
   import utf8_sd_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   class utf8_ledger;
      out_type due_points[$];
      out_type fresh[$];
      logic [CP_W-1:0] seq_value;
      logic [LEN_W-1:0] seq_length;
      logic [LEN_W-1:0] seq_taken;
      int wrong;

      function new();
         seq_value = '0;
         seq_length = '0;
         seq_taken = '0;
         wrong = 0;
      endfunction

      function out_type point(logic [CP_W-1:0] cp, logic [LEN_W-1:0] used, logic bad);
         out_type r;
         r.code_point = cp;
         r.bytes_used = used;
         r.malformed = bad;
         r.run_last = 1'b0;
         r.text_done = 1'b0;
         return r;
      endfunction

      function void close_seq();
         seq_value = '0;
         seq_length = '0;
         seq_taken = '0;
      endfunction

      function void open_lead(logic [7:0] b);
         casez (b)
            8'b0???????: begin
               fresh.push_back(point(CP_W'(b), 3'd1, 1'b0));
               return;
            end
            8'b110?????: begin
               seq_value = CP_W'(b[4:0]);
               seq_length = 3'd2;
            end
            8'b1110????: begin
               seq_value = CP_W'(b[3:0]);
               seq_length = 3'd3;
            end
            8'b11110???: begin
               seq_value = CP_W'(b[2:0]);
               seq_length = 3'd4;
            end
            default: begin
               fresh.push_back(point(REPLACEMENT_CP, 3'd1, 1'b1));
               return;
            end
         endcase
         seq_taken = 3'd1;
      endfunction

      // Works out the code points that one accepted transfer releases.
      function void absorb_byte(in_type item);
         logic [7:0] b;
         b = item.text_byte;
         fresh.delete();
         if (seq_length != 0) begin
            if (b[7:6] == 2'b10) begin
               seq_value = {seq_value[CP_W-7:0], b[5:0]};
               seq_taken = seq_taken + 3'd1;
               if (seq_taken >= seq_length) begin
                  fresh.push_back(point(seq_value, seq_taken, 1'b0));
                  close_seq();
               end
            end else begin
               fresh.push_back(point(REPLACEMENT_CP, seq_taken, 1'b1));
               close_seq();
               open_lead(b);
            end
         end else begin
            open_lead(b);
         end
         if (item.is_final_byte && seq_length != 0) begin
            fresh.push_back(point(REPLACEMENT_CP, seq_taken, 1'b1));
            close_seq();
         end
         if (fresh.size() > 0) begin
            fresh[fresh.size()-1].run_last = 1'b1;
            fresh[fresh.size()-1].text_done = item.is_final_byte;
         end
         foreach (fresh[i]) due_points.push_back(fresh[i]);
      endfunction

      function void check_point(out_type got);
         out_type want;
         if (due_points.size() == 0) begin
            $error("code point %h arrived with none expected", got.code_point);
            wrong++;
            return;
         end
         want = due_points.pop_front();
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, got.code_point);
            wrong++;
         end
         if (got.bytes_used !== want.bytes_used) begin
            $error("bytes_used: expected %0d, got %0d", want.bytes_used, got.bytes_used);
            wrong++;
         end
         if (got.malformed !== want.malformed) begin
            $error("malformed: expected %b, got %b", want.malformed, got.malformed);
            wrong++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, got.run_last);
            wrong++;
         end
         if (got.text_done !== want.text_done) begin
            $error("text_done: expected %b, got %b", want.text_done, got.text_done);
            wrong++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   in_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   out_type rsp_data;

   utf8_ledger ledger = new();
   int phase = 0;
   int send_idle = 7;
   int recv_idle = 80;
   int bytes_sent = 0;

   utf8_stream_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      in_type item;
      item.text_byte = b;
      item.is_final_byte = fin;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      ledger.absorb_byte(item);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      logic [7:0] text[$];
      int chars;
      int pick;
      int len;
      int keep;
      chars = $urandom_range(1, 12);
      repeat (chars) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            text.push_back(8'($urandom_range(1, 127)));
         end else if (pick < 88) begin
            len = (pick < 50) ? 2 : (pick < 65) ? 3 : 4;
            keep = len;
            if (pick >= 80) begin
               len = $urandom_range(2, 4);
               keep = $urandom_range(1, len - 1);
            end
            case (len)
               2: text.push_back({3'b110, 5'($urandom)});
               3: text.push_back({4'b1110, 4'($urandom)});
               default: text.push_back({5'b11110, 3'($urandom)});
            endcase
            repeat (keep - 1) text.push_back({2'b10, 6'($urandom)});
         end else if (pick < 94) begin
            text.push_back(pick[0] ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)});
         end else begin
            text.push_back(8'($urandom_range(1, 255)));
         end
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      int hold_left;
      logic held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == 2 && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_point(rsp_data);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("utf8_stream_decoder: mismatch");
      $finish;
   end

   initial begin
      logic [8:0] opening[] = '{
         9'h000, 9'h001, 9'h07F, 9'h080, 9'h0F8, 9'h0FF,
         9'h0C3, 9'h0A9,
         9'h0E2, 9'h082, 9'h0AC,
         9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
         9'h0E2, 9'h082, 9'h041,
         9'h0C3, 9'h0FF,
         9'h0E2, 9'h080, 9'h0F0, 9'h190,
         9'h1DF,
         9'h0C3, 9'h1E2
      };
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
      while (bytes_sent < 350) send_text();

      phase = 1;
      send_idle = 80;
      recv_idle = 7;
      while (bytes_sent < 700) send_text();

      phase = 2;
      send_idle = 0;
      recv_idle = 0;
      while (bytes_sent < 1050) send_text();

      req_valid <= 1'b0;
      while (ledger.due_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (ledger.wrong == 0) begin
         $display("utf8_stream_decoder: match");
      end else begin
         $display("utf8_stream_decoder: mismatch");
      end
      $finish;
   end

endmodule
